// ----- rtl/core/pcx_rle_palette_decoder_assert.svh -----
// Assertion macros for the PCX run-length palette decoder.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef PCX_RLE_PALETTE_DECODER_ASSERT_SVH
`define PCX_RLE_PALETTE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PCXRLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PCXRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pcxrle_pkg.sv -----
// Shared types and constants of the PCX run-length palette decoder.
// No dependencies.
`default_nettype none

package pcxrle_pkg;

  localparam int DimW      = 13;
  localparam int TotalW    = 25;
  localparam int PosW      = 24;
  localparam int RunW      = 6;
  localparam int PalAddrW  = 8;
  localparam int RgbW      = 24;
  localparam int PalEntries = 256;

  localparam logic [DimW-1:0] MaxDimension = 13'd4096;
  localparam logic [7:0]      RunMark      = 8'd192;
  localparam logic [7:0]      AlphaOpaque  = 8'hFF;

  // Request kinds
  localparam logic KindPalette = 1'b0;
  localparam logic KindData    = 1'b1;

  // Register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic                en;
    logic [PalAddrW-1:0] addr;
    logic [RgbW-1:0]     rgb;
  } pal_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/pcxrle_palette_ram.sv -----
// Palette store: 256 x 24-bit synchronous RAM, one write and one read port.
// Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_palette_ram (
  input  wire logic                              clk_i,
  input  wire pcxrle_pkg::pal_wr_t               wr_i,
  input  wire logic                              rd_en_i,
  input  wire logic [pcxrle_pkg::PalAddrW-1:0]   rd_addr_i,
  output logic      [pcxrle_pkg::RgbW-1:0]       rd_data_o
);

  logic [pcxrle_pkg::RgbW-1:0] mem_q [pcxrle_pkg::PalEntries];
  logic [pcxrle_pkg::RgbW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.rgb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/pcxrle_cfg.sv -----
// Configuration registers (image width and height) on an APB-style port,
// with the clamped pixel total registered. Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output logic      [pcxrle_pkg::TotalW-1:0]      total_o
);

  logic [pcxrle_pkg::DimW-1:0]   width_q, height_q;
  logic [pcxrle_pkg::DimW-1:0]   width_c, height_c;
  logic [2*pcxrle_pkg::DimW-1:0] product;
  logic [pcxrle_pkg::TotalW-1:0] total_q;
  logic                          wr_en;
  logic                          reg_sel;

  function automatic logic [pcxrle_pkg::DimW-1:0] clamp_dim(
    input logic [pcxrle_pkg::DimW-1:0] v
  );
    logic [pcxrle_pkg::DimW-1:0] r;
    if (v == '0) begin
      r = {{(pcxrle_pkg::DimW-1){1'b0}}, 1'b1};
    end else if (v > pcxrle_pkg::MaxDimension) begin
      r = pcxrle_pkg::MaxDimension;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= {{(pcxrle_pkg::DimW-1){1'b0}}, 1'b1};
      height_q <= {{(pcxrle_pkg::DimW-1){1'b0}}, 1'b1};
    end else if (wr_en) begin
      case (reg_sel)
        pcxrle_pkg::RegWidth:  width_q  <= pwdata[pcxrle_pkg::DimW-1:0];
        pcxrle_pkg::RegHeight: height_q <= pwdata[pcxrle_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pcxrle_pkg::RegWidth:  prdata = {{(32-pcxrle_pkg::DimW){1'b0}}, width_q};
      pcxrle_pkg::RegHeight: prdata = {{(32-pcxrle_pkg::DimW){1'b0}}, height_q};
      default:               prdata = '0;
    endcase
  end

  assign width_c  = clamp_dim(width_q);
  assign height_c = clamp_dim(height_q);
  assign product  = width_c * height_c;

  // Register the product of the clamped width and height.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= {{(pcxrle_pkg::TotalW-1){1'b0}}, 1'b1};
    end else begin
      total_q <= product[pcxrle_pkg::TotalW-1:0];
    end
  end

  assign total_o = total_q;

endmodule

`default_nettype wire

// ----- rtl/core/pcx_rle_palette_decoder.sv -----
// PCX run-length decoder: palette writes and run headers are taken in StIdle; a
// data byte is accepted in StIdle (starting the palette RAM read), checked in
// StLook, then emitted one pixel per cycle while out_stall_i is low, or dropped
// if the image is complete. New requests are stalled until back in StIdle.
// Reset (rst_ni low, async) clears run state, pixel counter and sizes to 1x1;
// the palette is undefined until written.
`default_nettype none

module pcx_rle_palette_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  palette_index_i,
  input  wire logic [7:0]  palette_red_i,
  input  wire logic [7:0]  palette_green_i,
  input  wire logic [7:0]  palette_blue_i,
  // Pixel channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  red_o,
  output logic      [7:0]  green_o,
  output logic      [7:0]  blue_o,
  output logic      [7:0]  alpha_o,
  output logic      [23:0] pixel_position_o,
  output logic             run_end_o,
  output logic             image_end_o
);

  // Sequencer states: take requests, wait on the palette read, emit pixels.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLook = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic                              run_pend_q, run_pend_d;
  logic [pcxrle_pkg::RunW-1:0]       run_len_q, run_len_d;
  logic [pcxrle_pkg::RunW-1:0]       remain_q, remain_d;
  logic [pcxrle_pkg::TotalW-1:0]     pix_cnt_q, pix_cnt_d;
  logic [pcxrle_pkg::TotalW-1:0]     pix_next;
  logic [pcxrle_pkg::TotalW-1:0]     total;
  logic [pcxrle_pkg::RgbW-1:0]       rgb;
  pcxrle_pkg::pal_wr_t               pal_wr;
  logic                              in_acc, out_acc, data_acc;
  logic                              last_pix, run_end;

  pcxrle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .total_o (total)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign data_acc   = in_acc && (kind_i == pcxrle_pkg::KindData);

  // Palette writes land at the accept edge; data bytes start a read there.
  assign pal_wr.en   = in_acc && (kind_i == pcxrle_pkg::KindPalette);
  assign pal_wr.addr = palette_index_i;
  assign pal_wr.rgb  = {palette_red_i, palette_green_i, palette_blue_i};

  pcxrle_palette_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (pal_wr),
    .rd_en_i   (data_acc),
    .rd_addr_i (data_byte_i),
    .rd_data_o (rgb)
  );

  assign out_valid_o = (state_q == StEmit);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign pix_next    = pix_cnt_q + {{(pcxrle_pkg::TotalW-1){1'b0}}, 1'b1};
  assign last_pix    = (pix_next == total);
  assign run_end     = (remain_q == {{(pcxrle_pkg::RunW-1){1'b0}}, 1'b1}) || last_pix;

  always_comb begin
    state_d    = state_q;
    run_pend_d = run_pend_q;
    run_len_d  = run_len_q;
    remain_d   = remain_q;
    pix_cnt_d  = pix_cnt_q;
    case (state_q)
      StIdle: begin
        if (data_acc) begin
          if (run_pend_q) begin
            // Index byte of a pending run: repeat it run_len_q times.
            run_pend_d = 1'b0;
            run_len_d  = '0;
            remain_d   = run_len_q;
            if (run_len_q != '0) begin
              state_d = StLook;
            end
          end else if (data_byte_i >= pcxrle_pkg::RunMark) begin
            // Run header: hold the count for the next data byte.
            run_pend_d = 1'b1;
            run_len_d  = data_byte_i[pcxrle_pkg::RunW-1:0];
          end else begin
            remain_d = {{(pcxrle_pkg::RunW-1){1'b0}}, 1'b1};
            state_d  = StLook;
          end
        end
      end
      StLook: begin
        // Drop the whole item once the image is complete.
        if (pix_cnt_q < total) begin
          state_d = StEmit;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (out_acc) begin
          pix_cnt_d = pix_next;
          remain_d  = remain_q - {{(pcxrle_pkg::RunW-1){1'b0}}, 1'b1};
          if (run_end) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      run_pend_q <= 1'b0;
      run_len_q  <= '0;
      remain_q   <= '0;
      pix_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      run_pend_q <= run_pend_d;
      run_len_q  <= run_len_d;
      remain_q   <= remain_d;
      pix_cnt_q  <= pix_cnt_d;
    end
  end

  // Pixel fields come straight from held registers, stable while stalled.
  assign red_o            = rgb[23:16];
  assign green_o          = rgb[15:8];
  assign blue_o           = rgb[7:0];
  assign alpha_o          = pcxrle_pkg::AlphaOpaque;
  assign pixel_position_o = pix_cnt_q[pcxrle_pkg::PosW-1:0];
  assign run_end_o        = run_end;
  assign image_end_o      = last_pix;

`include "pcx_rle_palette_decoder_assert.svh"

  `PCXRLE_ASSERT_NOW(a_emit_in_image, out_valid_o, (pix_cnt_q < total), "pixel beyond image end")
  `PCXRLE_ASSERT_NOW(a_emit_has_count, out_valid_o, (remain_q != '0), "emit with empty run")
  `PCXRLE_ASSERT_NEXT(a_run_end_stops, (out_acc && run_end_o), !out_valid_o, "emit after run end")

endmodule

`default_nettype wire
